// File: rtl/cic_pkg.sv
package cic_pkg;

  localparam int unsigned CIC_STAGES    = 3;
  localparam int unsigned CIC_MAX_DELAY = 2;
  localparam int unsigned FIFO_DEPTH    = 2;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned RATE_W     = 17;
  localparam int unsigned DELAY_W    = 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd8;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 2'd1;

  typedef enum logic [0:0] {
    REG_DECIM_RATE = 1'b0,
    REG_COMB_DELAY = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [RATE_W-1:0]  decim_rate;
    logic [DELAY_W-1:0] comb_delay;
  } cfg_t;

endpackage

// File: rtl/cic_fifo.sv
module cic_fifo import cic_pkg::*; #(
  parameter int unsigned WIDTH = DATA_W,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/cic_front.sv
module cic_front import cic_pkg::*; #(
  parameter int unsigned STAGES = CIC_STAGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [RATE_W-1:0]          decim_rate_i,
  output logic                       emit_o,
  output logic [DATA_W-1:0]          data_o
);

  logic [DATA_W-1:0] acc_q [STAGES];
  logic [DATA_W-1:0] acc_d [STAGES];
  logic [DATA_W-1:0] sample_ext;
  logic [RATE_W-1:0] phase_q, phase_inc, eff_rate;
  logic              frame_done;

  assign sample_ext = {{(DATA_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};

  // Integrator 1 sees the updated integrator 0; higher ones see the old value below.
  for (genvar k = 0; k < STAGES; k++) begin : g_integ
    if (k == 0) begin : g_first
      assign acc_d[k] = acc_q[0] + sample_ext;
    end else if (k == 1) begin : g_second
      assign acc_d[k] = acc_q[1] + acc_q[0] + sample_ext;
    end else begin : g_rest
      assign acc_d[k] = acc_q[k] + acc_q[k-1];
    end
  end

  assign phase_inc  = phase_q + 1'b1;
  assign eff_rate   = (decim_rate_i == '0) ? RATE_W'(1) : decim_rate_i;
  assign frame_done = (phase_inc >= eff_rate);
  assign emit_o     = accept_i && frame_done;
  assign data_o     = acc_d[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) begin
        acc_q[i] <= '0;
      end
      phase_q <= '0;
    end else if (accept_i) begin
      for (int i = 0; i < STAGES; i++) begin
        acc_q[i] <= acc_d[i];
      end
      phase_q <= frame_done ? '0 : phase_inc;
    end
  end

endmodule

// File: rtl/cic_comb.sv
module cic_comb import cic_pkg::*; #(
  parameter int unsigned STAGES    = CIC_STAGES,
  parameter int unsigned MAX_DELAY = CIC_MAX_DELAY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [DELAY_W-1:0]  comb_delay_i,
  input  logic                in_valid_i,
  input  logic [DATA_W-1:0]   in_data_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output logic [DATA_W-1:0]   out_data_o,
  input  logic                out_ready_i
);

  localparam int unsigned RW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

  logic [RW-1:0]     ring_q, ring_d, slot;
  logic [RW:0]       eff_delay;
  logic [RW:0]       wrap_val;
  logic              advance;

  logic [DATA_W-1:0] din_w   [STAGES];
  logic [RW-1:0]     sin_w   [STAGES];
  logic              vin_w   [STAGES];
  logic [DATA_W-1:0] dout_w  [STAGES];
  logic              vout_w  [STAGES];

  // The whole pipeline holds only when the last stage cannot hand off its result.
  assign advance     = !(vout_w[STAGES-1] && !out_ready_i);
  assign in_ready_o  = advance;
  assign out_valid_o = vout_w[STAGES-1];
  assign out_data_o  = dout_w[STAGES-1];

  assign slot = (32'(ring_q) < MAX_DELAY) ? ring_q : '0;

  always_comb begin
    if (comb_delay_i == '0) begin
      eff_delay = (RW+1)'(1);
    end else if (32'(comb_delay_i) > MAX_DELAY) begin
      eff_delay = (RW+1)'(MAX_DELAY);
    end else begin
      eff_delay = (RW+1)'(comb_delay_i);
    end
    wrap_val = {1'b0, slot} + 1'b1;
    for (int i = 0; i < MAX_DELAY; i++) begin
      if (wrap_val >= eff_delay) begin
        wrap_val = wrap_val - eff_delay;
      end
    end
    ring_d = wrap_val[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
    end else if (advance && in_valid_i) begin
      ring_q <= ring_d;
    end
  end

  assign din_w[0] = in_data_i;
  assign sin_w[0] = slot;
  assign vin_w[0] = in_valid_i;

  for (genvar c = 0; c < STAGES; c++) begin : g_stage
    logic [DATA_W-1:0] line_q [MAX_DELAY];
    logic [DATA_W-1:0] val_q;
    logic              valid_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < MAX_DELAY; i++) begin
          line_q[i] <= '0;
        end
        valid_q <= 1'b0;
      end else if (advance) begin
        if (vin_w[c]) begin
          line_q[sin_w[c]] <= din_w[c];
        end
        valid_q <= vin_w[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        val_q <= din_w[c] - line_q[sin_w[c]];
      end
    end

    assign dout_w[c] = val_q;
    assign vout_w[c] = valid_q;

    if (c < STAGES - 1) begin : g_link
      logic [RW-1:0] slot_q;

      always_ff @(posedge clk_i) begin
        if (advance) begin
          slot_q <= sin_w[c];
        end
      end

      assign din_w[c+1] = val_q;
      assign sin_w[c+1] = slot_q;
      assign vin_w[c+1] = valid_q;
    end
  end

endmodule

// File: rtl/cic_decimator.sv
// Channel   Direction  Handshake                    Payload
// input     in         push / full                  sample_i (16-bit signed)
// result    out        empty / pop                  filtered_o (64-bit signed)
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One sample is accepted each cycle that full is low; the integrators update in that cycle.
// A result travels from the sample that closes its frame through the middle queue, the
// one-register-per-stage comb pipeline and the output queue to the result ports.
// Reset clears the integrators, the comb delay lines, the ring index and the phase count.
// full rises only when the output queue is full and pop is held low long enough to back
// the comb pipeline up into the two-entry queue behind the front.
module cic_decimator import cic_pkg::*; #(
  parameter int unsigned STAGES    = CIC_STAGES,
  parameter int unsigned MAX_DELAY = CIC_MAX_DELAY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [DATA_W-1:0]   filtered_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  cfg_t              cfg_q;
  reg_idx_e          reg_idx;
  logic              accept;
  logic              emit;
  logic [DATA_W-1:0] front_data;
  logic [DATA_W-1:0] mid_data;
  logic              mid_full, mid_empty;
  logic              comb_ready;
  logic              comb_valid;
  logic [DATA_W-1:0] comb_data;
  logic              out_full;
  logic [DATA_W-1:0] out_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decim_rate <= RATE_RESET;
      cfg_q.comb_delay <= DELAY_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DECIM_RATE: cfg_q.decim_rate <= pwdata[RATE_W-1:0];
        REG_COMB_DELAY: cfg_q.comb_delay <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DECIM_RATE: prdata = APB_DATA_W'(cfg_q.decim_rate);
      REG_COMB_DELAY: prdata = APB_DATA_W'(cfg_q.comb_delay);
      default:        prdata = '0;
    endcase
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;

  cic_front #(
    .STAGES(STAGES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sample_i     (sample_i),
    .decim_rate_i (cfg_q.decim_rate),
    .emit_o       (emit),
    .data_o       (front_data)
  );

  cic_fifo #(
    .WIDTH(DATA_W),
    .DEPTH(FIFO_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .data_i  (front_data),
    .pop_i   (comb_ready),
    .data_o  (mid_data),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  cic_comb #(
    .STAGES(STAGES),
    .MAX_DELAY(MAX_DELAY)
  ) u_comb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .comb_delay_i (cfg_q.comb_delay),
    .in_valid_i   (!mid_empty),
    .in_data_i    (mid_data),
    .in_ready_o   (comb_ready),
    .out_valid_o  (comb_valid),
    .out_data_o   (comb_data),
    .out_ready_i  (!out_full)
  );

  cic_fifo #(
    .WIDTH(DATA_W),
    .DEPTH(FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (comb_valid),
    .data_i  (comb_data),
    .pop_i   (pop),
    .data_o  (out_data),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign filtered_o = out_data;

endmodule

// File: sim/cic_checker.sv
module cic_checker import cic_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic signed [DATA_W-1:0]   filtered_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                outputs_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0]        integ_q [CIC_STAGES];
  logic [DATA_W-1:0]        comb_mem_q [CIC_STAGES*CIC_MAX_DELAY];
  int unsigned              ring_q;
  logic [RATE_W-1:0]        phase_q;
  logic [RATE_W-1:0]        rate_q;
  logic [DELAY_W-1:0]       delay_q;
  logic signed [DATA_W-1:0] awaited_filtered [$];
  logic signed [DATA_W-1:0] want;
  int unsigned              fails = 0;
  int unsigned              seen = 0;

  // Integrator 1 sees the freshly updated integrator 0; the higher ones see the old value
  // of their neighbor because they are updated from the top down.
  function automatic void integrate_and_decimate(input logic signed [SAMPLE_W-1:0] s);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] old;
    logic [RATE_W-1:0] eff_rate;
    int unsigned       slot;
    int unsigned       eff_delay;
    int unsigned       pos;
    integ_q[0] = integ_q[0] + {{(DATA_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
    for (int k = CIC_STAGES - 1; k >= 1; k--) begin
      integ_q[k] = integ_q[k] + integ_q[k-1];
    end
    phase_q  = phase_q + 1'b1;
    eff_rate = (rate_q == '0) ? RATE_W'(1) : rate_q;
    if (phase_q < eff_rate) return;
    phase_q = '0;
    slot = (ring_q < CIC_MAX_DELAY) ? ring_q : 0;
    acc  = integ_q[CIC_STAGES-1];
    for (int k = 0; k < CIC_STAGES; k++) begin
      pos             = k * CIC_MAX_DELAY + slot;
      old             = comb_mem_q[pos];
      comb_mem_q[pos] = acc;
      acc             = acc - old;
    end
    if (delay_q == '0) begin
      eff_delay = 1;
    end else if (delay_q > CIC_MAX_DELAY) begin
      eff_delay = CIC_MAX_DELAY;
    end else begin
      eff_delay = delay_q;
    end
    ring_q = (slot + 1) % eff_delay;
    awaited_filtered.push_back(acc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (integ_q[i]) integ_q[i] = '0;
      foreach (comb_mem_q[i]) comb_mem_q[i] = '0;
      ring_q  = 0;
      phase_q = '0;
      rate_q  = RATE_RESET;
      delay_q = DELAY_RESET;
      awaited_filtered.delete();
    end else begin
      if (pop && !empty) begin
        seen++;
        if (awaited_filtered.size() == 0) begin
          fails++;
          $display("%0t: unexpected output transfer, expected none, actual %0d",
                   $time, filtered_o);
        end else begin
          want = awaited_filtered.pop_front();
          if (filtered_o !== want) begin
            fails++;
            $display("%0t: filtered_o mismatch, expected %0d, actual %0d",
                     $time, want, filtered_o);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_ADDR_W-1]))
          REG_DECIM_RATE: rate_q  = pwdata[RATE_W-1:0];
          REG_COMB_DELAY: delay_q = pwdata[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) integrate_and_decimate(sample_i);
    end
    pending_o      <= awaited_filtered.size();
    fail_count_o   <= fails;
    outputs_seen_o <= seen;
  end

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cic_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = CIC_STAGES + 3;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [DATA_W-1:0]   filtered_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]      paddr = '0;
  logic [APB_DATA_W-1:0]      pwdata = '0;
  logic [APB_DATA_W-1:0]      prdata;
  logic                       pready;

  logic        no_idle = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned fail_count;
  int unsigned outputs_due;
  int unsigned outputs_seen;

  cic_decimator i_dut (.*);

  cic_checker i_checker (
    .*,
    .fail_count_o   (fail_count),
    .pending_o      (outputs_due),
    .outputs_seen_o (outputs_seen)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) pop <= no_idle || ($urandom_range(99) >= 26);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d outputs still due",
               $time, quiet_cycles, outputs_due);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic signed [SAMPLE_W-1:0] s);
    while (!no_idle && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (full);
    samples_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (outputs_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return -16'sd1;
      4, 5:    return SAMPLE_W'($urandom_range(64)) - 16'sd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] draw_rate();
    case ($urandom_range(9))
      0:          return 0;
      1:          return 1;
      2, 3:       return $urandom_range(4, 2);
      4, 5, 6, 7: return $urandom_range(12, 5);
      8:          return $urandom_range(40, 13);
      default:    return 65536;
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(16'sh7fff);
    send(16'sh8000);
    send(16'sh0000);
    send(-16'sd1);
    send(16'sd1);
    send(16'sh5555);
    send(16'shaaaa);
    send(16'sh7fff);

    // A zero rate behaves as one, so every sample closes a frame.
    drain();
    cfg_write(REG_DECIM_RATE, 0);
    cfg_write(REG_COMB_DELAY, 2);
    send(16'sh7fff);
    send(16'sh7fff);
    send(16'sh8000);

    // The ring index sits at one here, beyond the new delay, so it is used once more.
    drain();
    cfg_write(REG_COMB_DELAY, 0);
    send(16'sh8000);
    send(16'sh1234);
    drain();
    cfg_write(REG_COMB_DELAY, 3);
    send(-16'sd300);
    send(16'sd77);

    // Large rates are only left partly filled and then lowered mid-frame.
    drain();
    cfg_write(REG_DECIM_RATE, 131071);
    repeat (5) send(16'sh7fff);
    drain();
    cfg_write(REG_DECIM_RATE, 65536);
    repeat (3) send(16'sh8000);
    drain();
    cfg_write(REG_DECIM_RATE, 2);
    send(16'sd5);

    for (int p = 0; p < 10; p++) begin
      no_idle <= (p == 4);
      drain();
      cfg_write(REG_DECIM_RATE, draw_rate());
      cfg_write(REG_COMB_DELAY, $urandom_range(3));
      repeat (92) send(draw_sample());
      drain();
      cfg_write(REG_DECIM_RATE, draw_rate());
      cfg_write(REG_COMB_DELAY, $urandom_range(3));
      repeat (93) send(draw_sample());
    end
    no_idle <= 1'b0;
    drain();

    $display("%0d samples sent and %0d decimated outputs compared,", samples_sent,
             outputs_seen);
    $display("over rates from 0 to 131071 and comb delays from 0 to 3.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
